>>> rtl/core/tbpc_pkg.sv
// Package for the two-button press classifier: word types, codes and judge function.
package tbpc_pkg;

   // Button status codes
   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_PRESS = 2'd1;
   localparam logic [1:0] ST_SHORT = 2'd2;
   localparam logic [1:0] ST_LONG  = 2'd3;

   // Combined event codes
   localparam logic [2:0] EV_RELEASED   = 3'd0;
   localparam logic [2:0] EV_OPEN       = 3'd1;
   localparam logic [2:0] EV_CLOSE      = 3'd2;
   localparam logic [2:0] EV_OPEN_LONG  = 3'd3;
   localparam logic [2:0] EV_CLOSE_LONG = 3'd4;
   localparam logic [2:0] EV_BOTH       = 3'd5;
   localparam logic [2:0] EV_OPEN_REL   = 3'd6;
   localparam logic [2:0] EV_CLOSE_REL  = 3'd7;

   localparam int unsigned HoldoffWidth = 16;
   localparam logic [HoldoffWidth-1:0] HOLDOFF_RESET = 16'd500;

   typedef struct packed {
      logic open_level;
      logic close_level;
   } req_word_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic [1:0] open_state;
      logic [1:0] close_state;
   } rsp_word_type;

   // New status of one button from its previous and current status and its level
   function automatic logic [1:0] judge(input logic [1:0] prev, input logic [1:0] cur,
                                        input logic level);
      logic [1:0] res;
      if (level) begin
         if (prev == ST_PRESS) begin
            res = ST_LONG;
         end else if (prev == ST_NONE) begin
            res = ST_PRESS;
         end else begin
            res = cur;
         end
      end else begin
         res = (prev == ST_PRESS) ? ST_SHORT : ST_NONE;
      end
      return res;
   endfunction

   // Short or long: the press is finished
   function automatic logic is_done(input logic [1:0] s);
      return (s == ST_SHORT) || (s == ST_LONG);
   endfunction

endpackage

>>> rtl/core/two_button_press_classifier.sv
// Top level of the two-button press classifier: input stage, status update, result register.
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  req     | req_valid, req_stall, req_word      | in
//  rsp     | rsp_valid, rsp_stall, rsp_word      | out
//  csr     | csr_valid, csr_ready, csr_data      | in (holdoff_ticks)
//
// One word per cycle while the result register is free; a word is held in the input
// register and its result (if any) is then registered in the result register.
// A single status update lies between those two registers.
// A word that causes no event passes through without producing a result.
// Reset (synchronous) clears statuses, holdoff counters and last event, and
// loads holdoff_ticks with 500; no clearing pass is needed.
// A stalled result holds the input register, which then stalls req.
module two_button_press_classifier (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tbpc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tbpc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);
   import tbpc_pkg::*;

   logic                    in_valid_ff;
   req_word_type            in_word_ff;
   logic                    out_valid_ff, out_valid_in;
   rsp_word_type            out_word_ff, out_word_in;
   logic [HoldoffWidth-1:0] holdoff_ticks_ff;
   logic [1:0]              cur_ff [2];
   logic [1:0]              cur_in [2];
   logic [1:0]              prev_ff [2];
   logic [1:0]              prev_in [2];
   logic [HoldoffWidth-1:0] hold_ff [2];
   logic [HoldoffWidth-1:0] hold_in [2];
   logic [2:0]              last_ev_ff, last_ev_in;
   logic                    out_free, fire, changed;
   logic [1:0]              level;
   logic [1:0]              judged [2];
   logic [1:0]              chg;
   logic [2:0]              ev;

   // Handshake: the input stage moves when the result register is free
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   assign level = {in_word_ff.close_level, in_word_ff.open_level};

   // Per-button judge and holdoff update
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         judged[i] = judge(prev_ff[i], cur_ff[i], level[i]);
         chg[i]    = 1'b0;
         cur_in[i] = cur_ff[i];
         hold_in[i] = hold_ff[i];
         if (fire) begin
            if (hold_ff[i] == '0) begin
               cur_in[i] = judged[i];
               if (judged[i] != prev_ff[i]) begin
                  chg[i]     = 1'b1;
                  hold_in[i] = holdoff_ticks_ff;
               end
            end else begin
               hold_in[i] = hold_ff[i] - 1'b1;
            end
         end
      end
      changed = |chg;
   end

   // Event priority on the new statuses
   always_comb begin
      if (last_ev_ff == EV_BOTH) begin
         ev = EV_RELEASED;
      end else if (is_done(cur_in[0]) && is_done(cur_in[1])) begin
         ev = EV_BOTH;
      end else if (cur_in[0] == ST_SHORT) begin
         ev = EV_OPEN;
      end else if (cur_in[1] == ST_SHORT) begin
         ev = EV_CLOSE;
      end else if (cur_in[0] == ST_LONG) begin
         ev = EV_OPEN_LONG;
      end else if (cur_in[1] == ST_LONG) begin
         ev = EV_CLOSE_LONG;
      end else if (cur_in[0] == ST_NONE && prev_ff[0] == ST_LONG) begin
         ev = EV_OPEN_REL;
      end else if (cur_in[1] == ST_NONE && prev_ff[1] == ST_LONG) begin
         ev = EV_CLOSE_REL;
      end else begin
         ev = EV_RELEASED;
      end
   end

   // Commit event, copy status to previous, load result register
   always_comb begin
      last_ev_in   = last_ev_ff;
      prev_in      = prev_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_word_in  = out_word_ff;
      if (fire && changed) begin
         last_ev_in             = ev;
         prev_in                = cur_in;
         out_valid_in           = 1'b1;
         out_word_in.event_code  = ev;
         out_word_in.open_state  = cur_in[0];
         out_word_in.close_state = cur_in[1];
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         holdoff_ticks_ff <= HOLDOFF_RESET;
         last_ev_ff       <= EV_RELEASED;
         for (int i = 0; i < 2; i++) begin
            cur_ff[i]  <= ST_NONE;
            prev_ff[i] <= ST_NONE;
            hold_ff[i] <= '0;
         end
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         last_ev_ff   <= last_ev_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         hold_ff      <= hold_in;
         if (csr_valid && csr_ready) begin
            holdoff_ticks_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_word_ff <= req_word;
      end
      out_word_ff <= out_word_in;
   end

   // A "both" event carries two finished presses
   a_both_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.event_code == EV_BOTH |->
         is_done(out_word_ff.open_state) && is_done(out_word_ff.close_state))
      else $error("both event without two finished presses");

   // Previous status always tracks current between words
   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      cur_ff[0] == prev_ff[0] && cur_ff[1] == prev_ff[1])
      else $error("previous status out of step with current");

   // A button in holdoff keeps its status
   a_holdoff_open: assert property (@(posedge clock) disable iff (reset)
      fire && hold_ff[0] != '0 |=> cur_ff[0] == $past(cur_ff[0]))
      else $error("open button judged during holdoff");

   a_holdoff_close: assert property (@(posedge clock) disable iff (reset)
      fire && hold_ff[1] != '0 |=> cur_ff[1] == $past(cur_ff[1]))
      else $error("close button judged during holdoff");

   // Two "both" events never follow one another
   a_both_toggle: assert property (@(posedge clock) disable iff (reset)
      fire && changed && last_ev_ff == EV_BOTH |-> ev == EV_RELEASED)
      else $error("both event repeated");

endmodule
